// ----- rtl/core/mrhr_pkg.sv -----
// ----------------------------------------------------------------------------
// mrhr_pkg
// shared types, constants and the crc step for the holding register responder
// ----------------------------------------------------------------------------
package mrhr_pkg;

  localparam int IDX_W = 6;   // width of a table index on the wire
  localparam int CNT_W = 7;   // register count of a valid read, 1..125

  localparam logic        OP_LOAD = 1'b0;
  localparam logic        OP_READ = 1'b1;

  localparam logic [15:0] MAX_REGS            = 16'd125;
  localparam logic [7:0]  EXC_ILLEGAL_ADDRESS = 8'd2;
  localparam logic [7:0]  EXC_ILLEGAL_VALUE   = 8'd3;
  localparam logic [7:0]  FN_EXC_FLAG         = 8'h80;
  localparam logic [15:0] CRC_INIT            = 16'hFFFF;
  localparam logic [15:0] CRC_POLY            = 16'hA001;

  localparam logic [1:0]  BC_ONE = 2'd1;
  localparam logic [1:0]  BC_TWO = 2'd2;

  // one queued command, either a table load or a whole response frame
  typedef struct packed {
    logic             is_load;
    logic             is_normal;   // normal frame, else exception frame
    logic [7:0]       hdr0;
    logic [7:0]       hdr1;
    logic [7:0]       hdr2;
    logic [IDX_W-1:0] addr;        // load index or first register
    logic [15:0]      value;
    logic [CNT_W-1:0] count;
  } cmd_t;

  // modbus crc-16, reflected, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/modbus_read_holding_regs_responder_unit.sv -----
// ----------------------------------------------------------------------------
// modbus_read_holding_regs_responder_unit
// modbus function 03 responder: table loads and read-holding-register frames
// ----------------------------------------------------------------------------
// a load beat is written into the table ram when the back end pops it; a read walks the table
// one register at a time, each register read followed by its two frame bytes and, between
// registers, a wait state for the table ram; a new command is popped only once the frame is done
// exception frames carry the three header bytes and the crc; the 2-entry command queue absorbs input
// rst (synchronous) clears the queue, marks every table entry unwritten (read as zero) and sets slave_address=1
// ----------------------------------------------------------------------------
module modbus_read_holding_regs_responder_unit #(
  parameter int TABLE_DEPTH = 50
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: own slave id
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  // input beats
  input  logic        s_tvalid,
  output logic        s_tready,
  // table_index[5:0], table_value[21:6], req_slave_id[29:22],
  // req_function[37:30], req_start[53:38], req_count[69:54], zero pad
  input  logic [71:0] s_tdata,
  // opcode[0]
  input  logic        s_tuser,
  // output beats
  output logic        m_tvalid,
  input  logic        m_tready,
  // first_byte[7:0], second_byte[15:8]
  output logic [15:0] m_tdata,
  // byte_count[1:0]
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);
  import mrhr_pkg::*;

  logic       [7:0] slave_address;
  logic             s_accept;
  logic             fifo_push;
  logic             fifo_full;
  logic             fifo_pop;
  logic             fifo_empty;
  cmd_t             front_cmd;
  cmd_t             back_cmd;
  logic       [7:0] first_byte;
  logic       [7:0] second_byte;

  // own slave id; the user must write it only while the block is idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 8'd1;
    end else if (cfg_wr_en) begin
      slave_address <= cfg_wr_data;
    end
  end

  // the front takes a beat whenever the queue has room
  assign s_tready = !fifo_full;
  assign s_accept = s_tvalid && s_tready;

  mrhr_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .opcode        (s_tuser),
    .table_index   (s_tdata[5:0]),
    .table_value   (s_tdata[21:6]),
    .req_slave_id  (s_tdata[29:22]),
    .req_function  (s_tdata[37:30]),
    .req_start     (s_tdata[53:38]),
    .req_count     (s_tdata[69:54]),
    .slave_address (slave_address),
    .accept        (s_accept),
    .push          (fifo_push),
    .cmd           (front_cmd)
  );

  // loads and frames stay in order through one queue
  mrhr_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (fifo_push),
    .din   (front_cmd),
    .full  (fifo_full),
    .pop   (fifo_pop),
    .dout  (back_cmd),
    .empty (fifo_empty)
  );

  // table ram, crc and byte pairing with its own output register
  mrhr_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (fifo_empty),
    .cmd         (back_cmd),
    .pop         (fifo_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .first_byte  (first_byte),
    .second_byte (second_byte),
    .byte_count  (m_tuser),
    .last        (m_tlast)
  );

  assign m_tdata = {second_byte, first_byte};

  // every frame has an odd length, so only the closing beat carries one byte
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == BC_ONE)))
    else $error("byte count does not match frame end");

  // a single-byte beat has a zero upper byte
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == BC_ONE)) |-> (m_tdata[15:8] == 8'd0))
    else $error("unused byte not cleared");

  // the queue is never pushed while full
  assert property (@(posedge clk) disable iff (rst)
    fifo_full |-> !fifo_push)
    else $error("command queue overflow");

endmodule

// ----- rtl/core/mrhr_ram.sv -----
// ----------------------------------------------------------------------------
// mrhr_ram
// generic single write port ram with a registered read port
// ----------------------------------------------------------------------------
module mrhr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 50
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/mrhr_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// mrhr_cmd_fifo
// two-entry command queue between the front and the back
// ----------------------------------------------------------------------------
module mrhr_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mrhr_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output mrhr_pkg::cmd_t dout,
  output logic          empty
);
  import mrhr_pkg::*;

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/core/mrhr_front.sv -----
// ----------------------------------------------------------------------------
// mrhr_front
// accepts input beats, checks requests and builds queue commands
// ----------------------------------------------------------------------------
module mrhr_front #(
  parameter int TABLE_DEPTH = 50
) (
  input  logic           opcode,
  input  logic [5:0]     table_index,
  input  logic [15:0]    table_value,
  input  logic [7:0]     req_slave_id,
  input  logic [7:0]     req_function,
  input  logic [15:0]    req_start,
  input  logic [15:0]    req_count,
  input  logic [7:0]     slave_address,
  input  logic           accept,
  output logic           push,
  output mrhr_pkg::cmd_t cmd
);
  import mrhr_pkg::*;

  logic [16:0] end_addr;
  logic        bad_count;
  logic        bad_addr;
  logic        load_ok;

  // end address in 17 bits so it never wraps
  assign end_addr  = {1'b0, req_start} + {1'b0, req_count} - 17'd1;
  assign bad_count = (req_count == 16'd0) || (req_count > MAX_REGS);
  assign bad_addr  = end_addr > 17'(TABLE_DEPTH - 1);
  assign load_ok   = {26'd0, table_index} < 32'(TABLE_DEPTH);

  // out-of-range loads are dropped here
  assign push = accept && ((opcode == OP_READ) || load_ok);

  always_comb begin
    cmd           = '0;
    cmd.is_load   = (opcode == OP_LOAD);
    cmd.value     = table_value;
    cmd.count     = req_count[CNT_W-1:0];
    if (opcode == OP_LOAD) begin
      cmd.addr = table_index;
    end else begin
      cmd.addr = req_start[IDX_W-1:0];
      if (bad_count) begin
        cmd.hdr0 = req_slave_id;
        cmd.hdr1 = req_function | FN_EXC_FLAG;
        cmd.hdr2 = EXC_ILLEGAL_VALUE;
      end else if (bad_addr) begin
        cmd.hdr0 = req_slave_id;
        cmd.hdr1 = req_function | FN_EXC_FLAG;
        cmd.hdr2 = EXC_ILLEGAL_ADDRESS;
      end else begin
        cmd.is_normal = 1'b1;
        cmd.hdr0      = slave_address;
        cmd.hdr1      = req_function;
        cmd.hdr2      = {req_count[CNT_W-1:0], 1'b0};
      end
    end
  end

endmodule

// ----- rtl/core/mrhr_back.sv -----
// ----------------------------------------------------------------------------
// mrhr_back
// executes loads, walks the table and streams frame bytes with the crc
// ----------------------------------------------------------------------------
module mrhr_back #(
  parameter int TABLE_DEPTH = 50
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  mrhr_pkg::cmd_t cmd,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     first_byte,
  output logic [7:0]     second_byte,
  output logic [1:0]     byte_count,
  output logic           last
);
  import mrhr_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_HDR    = 3'd1;
  localparam logic [2:0] ST_DATA   = 3'd2;
  localparam logic [2:0] ST_WAIT   = 3'd3;
  localparam logic [2:0] ST_CRC_LO = 3'd4;
  localparam logic [2:0] ST_CRC_HI = 3'd5;

  logic [2:0]             state;
  logic [1:0]             hdr_idx;
  logic [CNT_W-1:0]       rem;
  logic                   hi;
  logic [AW-1:0]          rd_addr;
  logic [15:0]            crc;
  logic [7:0]             hold_byte;
  logic                   have_hold;
  cmd_t                   cur;
  logic [TABLE_DEPTH-1:0] valid;
  logic                   vld_q;
  logic [15:0]            rdata;
  logic [15:0]            word;
  logic                   emitting;
  logic                   final_byte;
  logic                   need_push;
  logic                   can_push;
  logic                   byte_go;
  logic                   push;
  logic [7:0]             cur_byte;
  logic                   ram_we;

  assign pop    = (state == ST_IDLE) && !empty;
  assign ram_we = pop && cmd.is_load;

  mrhr_ram #(
    .WIDTH (16),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cmd.addr[AW-1:0]),
    .wdata (cmd.value),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_q <= 1'b0;
    end else begin
      if (ram_we) begin
        valid[cmd.addr[AW-1:0]] <= 1'b1;
      end
      vld_q <= valid[rd_addr];
    end
  end

  assign word = vld_q ? rdata : 16'd0;

  always_comb begin
    unique case (state)
      ST_HDR: begin
        unique case (hdr_idx)
          2'd0:    cur_byte = cur.hdr0;
          2'd1:    cur_byte = cur.hdr1;
          default: cur_byte = cur.hdr2;
        endcase
      end
      ST_DATA:   cur_byte = hi ? word[15:8] : word[7:0];
      ST_CRC_LO: cur_byte = crc[7:0];
      ST_CRC_HI: cur_byte = crc[15:8];
      default:   cur_byte = 8'd0;
    endcase
  end

  assign emitting   = (state == ST_HDR) || (state == ST_DATA) ||
                      (state == ST_CRC_LO) || (state == ST_CRC_HI);
  assign final_byte = (state == ST_CRC_HI);
  assign need_push  = have_hold || final_byte;
  assign can_push   = !out_valid || out_ready;
  assign byte_go    = emitting && (!need_push || can_push);
  assign push       = byte_go && need_push;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= cmd;
    end
    if (byte_go && !need_push) begin
      hold_byte <= cur_byte;
    end
    if (push) begin
      first_byte  <= have_hold ? hold_byte : cur_byte;
      second_byte <= have_hold ? cur_byte : 8'd0;
      byte_count  <= have_hold ? BC_TWO : BC_ONE;
      last        <= final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      hdr_idx   <= 2'd0;
      rem       <= '0;
      hi        <= 1'b1;
      rd_addr   <= '0;
      crc       <= CRC_INIT;
      have_hold <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (byte_go) begin
        have_hold <= !need_push;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop && !cmd.is_load) begin
            state   <= ST_HDR;
            hdr_idx <= 2'd0;
            crc     <= CRC_INIT;
            rd_addr <= cmd.addr[AW-1:0];
            rem     <= cmd.count;
            hi      <= 1'b1;
          end
        end
        ST_HDR: begin
          if (byte_go) begin
            crc     <= crc_byte(crc, cur_byte);
            hdr_idx <= hdr_idx + 2'd1;
            if (hdr_idx == 2'd2) begin
              state <= cur.is_normal ? ST_DATA : ST_CRC_LO;
            end
          end
        end
        ST_DATA: begin
          if (byte_go) begin
            crc <= crc_byte(crc, cur_byte);
            if (hi) begin
              hi <= 1'b0;
            end else if (rem == CNT_W'(1)) begin
              state <= ST_CRC_LO;
            end else begin
              rem     <= rem - CNT_W'(1);
              rd_addr <= rd_addr + AW'(1);
              hi      <= 1'b1;
              state   <= ST_WAIT;
            end
          end
        end
        ST_WAIT: begin
          state <= ST_DATA;
        end
        ST_CRC_LO: begin
          if (byte_go) begin
            state <= ST_CRC_HI;
          end
        end
        ST_CRC_HI: begin
          if (byte_go) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- test/modbus_read_holding_regs_responder_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modbus_read_holding_regs_responder_unit_test
// drives table loads and function 03 read requests into the responder and
// checks every output beat against a frame predictor with crc-16, with random
// sender bursts, receiver stalls and slave id changes between phases
// ----------------------------------------------------------------------------
module modbus_read_holding_regs_responder_unit_test;
  import mrhr_pkg::*;

  localparam int TABLE_DEPTH   = 50;
  localparam int SETTLE_CYCLES = 32;        // back end still busy with loads
  localparam int TIMEOUT_NS    = 2_000_000;
  localparam int DIR_ROWS      = 25;
  localparam int PHASES        = 5;
  localparam int PHASE_ITEMS   = 50;

  // one input beat, split into its fields
  typedef struct packed {
    logic        opcode;
    logic [5:0]  table_index;
    logic [15:0] table_value;
    logic [7:0]  req_slave_id;
    logic [7:0]  req_function;
    logic [15:0] req_start;
    logic [15:0] req_count;
  } request_t;

  // one output beat as the predictor expects it
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [1:0] nbytes;
    logic       eof;
  } frame_beat_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_READ} row_kind_t;
  typedef enum logic [1:0] {RX_STEADY, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  // directed row: cfg rows carry the slave id in value[7:0]; typed rows give
  // the three header bytes that the frame must start with
  typedef struct packed {
    row_kind_t   kind;
    logic [5:0]  idx;
    logic [15:0] value;
    logic [7:0]  id;
    logic [7:0]  fn;
    logic [15:0] start;
    logic [15:0] count;
    logic        typed;
    logic [7:0]  h0;
    logic [7:0]  h1;
    logic [7:0]  h2;
  } stim_row_t;

  //  kind      idx  value    id     fn     start    count   t  h0     h1     h2
  localparam stim_row_t STIM_TABLE [DIR_ROWS] = '{
    // after reset: zero table, own id 1
    '{ROW_READ,  0, 'h0000, 'h01, 'h03, 'h0000, 'h0001, 1, 'h01, 'h03, 'h02},
    // count zero, above 125, all ones
    '{ROW_READ,  0, 'h0000, 'hFF, 'h03, 'h0000, 'h0000, 1, 'hFF, 'h83, 'h03},
    '{ROW_READ,  0, 'h0000, 'h00, 'h00, 'h0000, 'h007E, 1, 'h00, 'h80, 'h03},
    '{ROW_READ,  0, 'h0000, 'h5A, 'h83, 'h0000, 'hFFFF, 1, 'h5A, 'h83, 'h03},
    // count valid but range past the table end
    '{ROW_READ,  0, 'h0000, 'h11, 'h03, 'h0000, 'h007D, 1, 'h11, 'h83, 'h02},
    '{ROW_READ,  0, 'h0000, 'h22, 'h03, 'h0031, 'h0002, 1, 'h22, 'h83, 'h02},
    // end address would wrap into the table with 16 bits
    '{ROW_READ,  0, 'h0000, 'h33, 'h03, 'hFFFF, 'h0002, 1, 'h33, 'h83, 'h02},
    '{ROW_READ,  0, 'h0000, 'h44, 'h04, 'hFFFA, 'h000A, 1, 'h44, 'h84, 'h02},
    // loads: both ends of the table, then indexes past it that are dropped
    '{ROW_LOAD,  0, 'hFFFF, 'h00, 'h00, 'h0000, 'h0000, 0, 'h00, 'h00, 'h00},
    '{ROW_LOAD, 49, 'h8001, 'h00, 'h00, 'h0000, 'h0000, 0, 'h00, 'h00, 'h00},
    '{ROW_LOAD,  1, 'hA5C3, 'h00, 'h00, 'h0000, 'h0000, 0, 'h00, 'h00, 'h00},
    '{ROW_LOAD, 50, 'h1234, 'h00, 'h00, 'h0000, 'h0000, 0, 'h00, 'h00, 'h00},
    '{ROW_LOAD, 63, 'hFFFF, 'h00, 'h00, 'h0000, 'h0000, 0, 'h00, 'h00, 'h00},
    // last entry alone, whole table, function byte echoed as is
    '{ROW_READ,  0, 'h0000, 'h00, 'h03, 'h0031, 'h0001, 1, 'h01, 'h03, 'h02},
    '{ROW_READ,  0, 'h0000, 'h00, 'h03, 'h0000, 'h0032, 1, 'h01, 'h03, 'h64},
    '{ROW_READ,  0, 'h0000, 'h00, 'hFF, 'h0000, 'h0002, 1, 'h01, 'hFF, 'h04},
    '{ROW_CFG,   0, 'h00FF, 'h00, 'h00, 'h0000, 'h0000, 0, 'h00, 'h00, 'h00},
    '{ROW_READ,  0, 'h0000, 'h00, 'h03, 'h0030, 'h0002, 1, 'hFF, 'h03, 'h04},
    '{ROW_CFG,   0, 'h0000, 'h00, 'h00, 'h0000, 'h0000, 0, 'h00, 'h00, 'h00},
    '{ROW_READ,  0, 'h0000, 'h00, 'h03, 'h0000, 'h0003, 1, 'h00, 'h03, 'h06},
    '{ROW_READ,  0, 'h0000, 'hFF, 'h7F, 'h0000, 'h0000, 1, 'hFF, 'hFF, 'h03},
    '{ROW_LOAD,  0, 'h0000, 'h00, 'h00, 'h0000, 'h0000, 0, 'h00, 'h00, 'h00},
    '{ROW_READ,  0, 'h0000, 'h00, 'h03, 'h0000, 'h0001, 0, 'h00, 'h00, 'h00},
    '{ROW_CFG,   0, 'h0001, 'h00, 'h00, 'h0000, 'h0000, 0, 'h00, 'h00, 'h00},
    '{ROW_READ,  0, 'h0000, 'h00, 'h03, 'h000A, 'h0005, 0, 'h00, 'h00, 'h00}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h00;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  // predictor state: register table and own slave id
  logic [15:0] holding_regs [TABLE_DEPTH];
  logic [7:0]  own_id;

  logic [7:0]  frame_bytes [$];     // frame under construction
  frame_beat_t pending_beats [$];   // beats still owed by the block
  int          mismatches = 0;

  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  rx_mode_t    rx_mode = RX_STEADY;
  int unsigned rx_cycle = 0;

  modbus_read_holding_regs_responder_unit #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // reflected crc-16, polynomial from the package, one byte at a time
  function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  // applies a load to the table, or fills frame_bytes with the response
  // (crc not yet appended); returns 1 when a frame is owed
  function automatic bit build_frame(request_t it);
    logic [31:0] last_addr;
    logic [15:0] v;
    frame_bytes.delete();
    if (it.opcode == OP_LOAD) begin
      // indexes past the table are dropped
      if (it.table_index < TABLE_DEPTH) holding_regs[it.table_index] = it.table_value;
      return 1'b0;
    end
    if (it.req_count == 16'd0 || it.req_count > MAX_REGS) begin
      frame_bytes = '{it.req_slave_id, it.req_function | FN_EXC_FLAG, EXC_ILLEGAL_VALUE};
      return 1'b1;
    end
    // end address in 32 bits, so a high start never wraps back into range
    last_addr = 32'(it.req_start) + 32'(it.req_count) - 32'd1;
    if (last_addr > 32'(TABLE_DEPTH - 1)) begin
      frame_bytes = '{it.req_slave_id, it.req_function | FN_EXC_FLAG, EXC_ILLEGAL_ADDRESS};
      return 1'b1;
    end
    frame_bytes = '{own_id, it.req_function, 8'(2 * it.req_count)};
    for (int a = int'(it.req_start); a <= int'(last_addr); a++) begin
      v = holding_regs[a];
      frame_bytes.push_back(v[15:8]);
      frame_bytes.push_back(v[7:0]);
    end
    return 1'b1;
  endfunction

  // appends the crc, low byte first, and splits the frame into 2-byte beats
  task automatic queue_frame();
    logic [15:0] crc;
    frame_beat_t beat;
    int          i;
    crc = CRC_INIT;
    foreach (frame_bytes[k]) crc = crc16_next(crc, frame_bytes[k]);
    frame_bytes.push_back(crc[7:0]);
    frame_bytes.push_back(crc[15:8]);
    for (i = 0; i < frame_bytes.size(); i += 2) begin
      beat.b0 = frame_bytes[i];
      if (i + 1 < frame_bytes.size()) begin
        beat.b1     = frame_bytes[i + 1];
        beat.nbytes = BC_TWO;
      end else begin
        beat.b1     = 8'h00;
        beat.nbytes = BC_ONE;
      end
      beat.eof = (i + 2 >= frame_bytes.size());
      pending_beats.push_back(beat);
    end
  endtask

  task automatic note_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  // holds the beat until the block takes it, then records what it owes
  task automatic push_item(input request_t it, input bit typed,
                           input logic [7:0] h0, input logic [7:0] h1,
                           input logic [7:0] h2);
    s_tvalid <= 1'b1;
    s_tuser  <= it.opcode;
    s_tdata  <= {2'b00, it.req_count, it.req_start, it.req_function,
                 it.req_slave_id, it.table_value, it.table_index};
    do @(posedge clk); while (!s_tready);
    if (build_frame(it)) begin
      // typed rows pin the header bytes; body and crc follow from the table
      if (typed) begin
        frame_bytes[0] = h0;
        frame_bytes[1] = h1;
        frame_bytes[2] = h2;
      end
      queue_frame();
    end
  endtask

  // sender bursts of random length with random gaps between them
  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (!gaps_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // sender holds off until every owed beat is out and the back end is quiet
  task automatic drain_outputs();
    s_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_slave_address(input logic [7:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    own_id = v;
  endtask

  // mostly loads and in-range reads with small counts, the rest broken reads
  function automatic request_t random_request();
    request_t    r;
    logic [95:0] noise;
    int          sel;
    int          span;
    noise = {$urandom(), $urandom(), $urandom()};
    r     = noise[70:0];
    sel   = $urandom_range(0, 99);
    if (sel < 35) begin
      r.opcode = OP_LOAD;
      if ($urandom_range(0, 9) != 0) r.table_index = 6'($urandom_range(0, TABLE_DEPTH - 1));
    end else begin
      r.opcode = OP_READ;
      if (sel < 85) begin
        r.req_start = 16'($urandom_range(0, TABLE_DEPTH - 1));
        span        = TABLE_DEPTH - int'(r.req_start);
        r.req_count = 16'(($urandom_range(0, 7) == 0) ? $urandom_range(1, span)
                                                      : $urandom_range(1, (span < 6) ? span : 6));
      end else begin
        case ($urandom_range(0, 4))
          0: r.req_count = 16'd0;
          1: r.req_count = 16'($urandom_range(126, 65535));
          2: ;  // fully random start and count
          3: begin
            r.req_start = 16'($urandom_range(0, TABLE_DEPTH - 1));
            r.req_count = 16'($urandom_range(TABLE_DEPTH + 1 - int'(r.req_start), 125));
          end
          default: begin
            // near the top of the address space, where 16-bit sums wrap
            r.req_start = 16'($urandom_range(65410, 65535));
            r.req_count = 16'($urandom_range(1, 125));
          end
        endcase
      end
    end
    return r;
  endfunction

  // output side: check each taken beat, then pick ready for the next cycle
  always @(posedge clk) begin
    frame_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_beats.size() == 0) begin
        note_mismatch($sformatf("output beat %h with nothing expected", m_tdata));
      end else begin
        want = pending_beats.pop_front();
        check_field("first_byte", m_tdata[7:0], want.b0);
        check_field("second_byte", m_tdata[15:8], want.b1);
        check_field("byte_count", {6'd0, m_tuser}, {6'd0, want.nbytes});
        check_field("last", {7'd0, m_tlast}, {7'd0, want.eof});
      end
    end
    rx_cycle <= rx_cycle + 1;
    // new stall pattern whenever the low seven bits of rx_cycle are zero
    if (rx_cycle[6:0] == 7'd0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_STEADY: m_tready <= 1'b1;
      RX_LIGHT:  m_tready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY:  m_tready <= ($urandom_range(0, 3) == 0);
      default:   m_tready <= (rx_cycle[3:0] < 4'd10);
    endcase
  end

  initial begin
    stim_row_t   r;
    request_t    req;
    int          row;
    int          phase;
    int          n;
    logic [7:0]  id;
    foreach (holding_regs[k]) holding_regs[k] = 16'h0000;
    own_id = 8'h01;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed rows
    for (row = 0; row < DIR_ROWS; row++) begin
      r = STIM_TABLE[row];
      if (r.kind == ROW_CFG) begin
        drain_outputs();
        write_slave_address(r.value[7:0]);
      end else begin
        req              = '0;
        req.opcode       = (r.kind == ROW_READ) ? OP_READ : OP_LOAD;
        req.table_index  = r.idx;
        req.table_value  = r.value;
        req.req_slave_id = r.id;
        req.req_function = r.fn;
        req.req_start    = r.start;
        req.req_count    = r.count;
        push_item(req, r.typed, r.h0, r.h1, r.h2);
        pace_sender();
      end
    end

    // random phases, each under its own slave id; phase 2 sends back to back
    for (phase = 0; phase < PHASES; phase++) begin
      drain_outputs();
      id = (phase == 0) ? 8'h00 : (phase == 1) ? 8'hFF : 8'($urandom());
      write_slave_address(id);
      gaps_on = (phase != 2);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // pause mid-phase until the block has caught up
        if (phase == 3 && n == PHASE_ITEMS / 2) drain_outputs();
        push_item(random_request(), 1'b0, 8'h00, 8'h00, 8'h00);
        pace_sender();
      end
    end

    drain_outputs();
    if (mismatches == 0) begin
      $display("modbus_read_holding_regs_responder_unit: match");
    end else begin
      $display("modbus_read_holding_regs_responder_unit: mismatch");
    end
    $finish;
  end

  // hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("modbus_read_holding_regs_responder_unit: mismatch");
    $finish;
  end

endmodule
